[hw/rtl/graph_adjacency_bit_matrix_assert.svh]
// assertion macros for the graph adjacency bit matrix checker
`ifndef GRAPH_ADJACENCY_BIT_MATRIX_ASSERT_SVH
`define GRAPH_ADJACENCY_BIT_MATRIX_ASSERT_SVH

// same-cycle implication, held off during reset
`define GABM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gabm check failed");

// next-cycle implication, held off during reset
`define GABM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gabm check failed");

// next-cycle implication, checked during reset as well
`define GABM_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gabm check failed");

`endif

[hw/rtl/gabm_pkg.sv]
// shared types, constants and helpers for the graph adjacency bit matrix
package gabm_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VERTEX_W     = 6;
  localparam int COUNT_W      = 7;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [COUNT_W-1:0] MAX_COUNT          = COUNT_W'(MAX_VERTICES);
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [1:0] {
    OP_CONNECT   = 2'd0,
    OP_QUERY     = 2'd1,
    OP_NEIGHBORS = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIRECTED     = 2'd0,
    REG_VERTEX_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CONN_TO,
    ST_EMIT_OK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic                connected;
    logic                has_neighbor;
    logic [VERTEX_W-1:0] neighbor;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    row_t              wr_data;
  } mem_req_t;

  function automatic row_t onehot_row(input logic [ADDR_W-1:0] idx);
    row_t r;
    r = '0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      r[k] = (idx == ADDR_W'(k));
    end
    return r;
  endfunction

endpackage

[hw/rtl/gabm_store.sv]
// edge row memory with per-row valid bits; unwritten rows read as self-loop only
module gabm_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  gabm_pkg::mem_req_t req,
  output gabm_pkg::row_t     rd_row
);
  import gabm_pkg::*;

  row_t                    mem [MAX_VERTICES];
  row_t                    mem_q;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    valid_q;
  logic [ADDR_W-1:0]       addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q   <= mem[req.rd_addr];
      valid_q <= row_valid[req.rd_addr];
      addr_q  <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_row = valid_q ? mem_q : onehot_row(addr_q);

endmodule

[hw/rtl/gabm_ctrl.sv]
// operation sequencer: read-modify-write of rows, query, neighbor walk, result register
module gabm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        directed,
  input  logic [gabm_pkg::COUNT_W-1:0] vertex_count,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gabm_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gabm_pkg::out_word_t         out_word,
  output gabm_pkg::mem_req_t          mem_req,
  input  gabm_pkg::row_t              rd_row
);
  import gabm_pkg::*;

  state_t            state;
  state_t            state_next;
  in_word_t          item;
  row_t              scan_row;
  row_t              scan_row_next;
  logic [ADDR_W-1:0] scan_idx;
  logic [ADDR_W-1:0] scan_idx_next;
  logic              emit;
  out_word_t         emit_word;

  logic [COUNT_W-1:0] active_n;
  row_t               count_mask;
  row_t               list_row;
  row_t               scan_rest;
  logic [ADDR_W-1:0]  from_a;
  logic [ADDR_W-1:0]  to_a;
  logic               from_ok;
  logic               pair_ok;
  logic               out_free;

  assign active_n  = (vertex_count > MAX_COUNT) ? MAX_COUNT : vertex_count;
  assign from_a    = item.from_vertex[ADDR_W-1:0];
  assign to_a      = item.to_vertex[ADDR_W-1:0];
  assign from_ok   = COUNT_W'(item.from_vertex) < active_n;
  assign pair_ok   = from_ok && (COUNT_W'(item.to_vertex) < active_n);
  assign out_free  = !out_valid || !out_stall;
  assign list_row  = rd_row & count_mask & ~onehot_row(from_a);
  assign scan_rest = scan_row & ~onehot_row(scan_idx);

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      count_mask[k] = COUNT_W'(k) < active_n;
    end
  end

  always_comb begin
    state_next    = state;
    scan_row_next = scan_row;
    scan_idx_next = scan_idx;
    mem_req       = '0;
    emit          = 1'b0;
    emit_word     = '0;
    in_stall      = (state != ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = in_word.from_vertex[ADDR_W-1:0];
          state_next      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        emit_word.last = 1'b1;
        case (item.operation)
          OP_CONNECT: begin
            if (!pair_ok) begin
              emit_word.status = 1'b1;
              emit             = out_free;
              if (out_free) begin
                state_next = ST_IDLE;
              end
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = from_a;
              mem_req.wr_data = rd_row | onehot_row(to_a);
              if (!directed && (to_a != from_a)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = to_a;
                state_next      = ST_CONN_TO;
              end else begin
                state_next = ST_EMIT_OK;
              end
            end
          end
          OP_QUERY: begin
            if (!pair_ok) begin
              emit_word.status = 1'b1;
            end else begin
              emit_word.connected = rd_row[to_a];
            end
            emit = out_free;
            if (out_free) begin
              state_next = ST_IDLE;
            end
          end
          OP_NEIGHBORS: begin
            if (!from_ok) begin
              emit_word.status = 1'b1;
              emit             = out_free;
              if (out_free) begin
                state_next = ST_IDLE;
              end
            end else begin
              scan_row_next = list_row;
              scan_idx_next = '0;
              if (list_row == '0) begin
                emit = out_free;
                if (out_free) begin
                  state_next = ST_IDLE;
                end
              end else begin
                state_next = ST_SCAN;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_CONN_TO: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = to_a;
        mem_req.wr_data = rd_row | onehot_row(from_a);
        emit_word.last  = 1'b1;
        emit            = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_OK: begin
        emit_word.last = 1'b1;
        emit           = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_row[scan_idx]) begin
          if (out_free) begin
            emit                   = 1'b1;
            emit_word.has_neighbor = 1'b1;
            emit_word.neighbor     = VERTEX_W'(scan_idx);
            emit_word.last         = (scan_rest == '0);
            scan_row_next          = scan_rest;
            scan_idx_next          = scan_idx + ADDR_W'(1);
            if (scan_rest == '0) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          scan_idx_next = scan_idx + ADDR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_word;
    end
    if (emit) begin
      out_word <= emit_word;
    end
    scan_row <= scan_row_next;
    scan_idx <= scan_idx_next;
  end

endmodule

[hw/rtl/graph_adjacency_bit_matrix.sv]
// top level of the graph adjacency bit matrix
//
// input channel in_valid / in_stall carries one word: operation, from_vertex, to_vertex
// output channel out_valid / out_stall returns result words; last marks the final
// word of each input word. operation code 3 gives no result.
// configuration: cfg_valid / cfg_ready with cfg_index (0 directed, 1 vertex_count)
// and cfg_data; cfg_ready is always high. a write to either register brings the
// edge store back to self-loops only; other indexes are ignored.
// one input word is worked on at a time. steps from accept to result word:
//   all: the row of from_vertex is read from the registered row memory
//   query: connected comes from that row; a range error gives an error word, no write
//   connect: the from row is written; when undirected and the vertices differ, the
//     to row is then read and written too (two row writes)
//   neighbor list: a walk over the row bit by bit up to the highest neighbor
// the next word is accepted in the cycle after the final result word is registered.
// a new word is taken while the last result still waits in the output register. a
// stalled receiver holds the output word and stops the walk at the next neighbor bit.
// reset sets directed 0, vertex_count 64 and marks every row as self-loop only
// at once, with no clearing pass.
module graph_adjacency_bit_matrix (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gabm_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gabm_pkg::out_word_t                out_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gabm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gabm_pkg::COUNT_W-1:0]       cfg_data
);
  import gabm_pkg::*;

  logic               directed;
  logic [COUNT_W-1:0] vertex_count;
  logic               cfg_wr;
  logic               clear_store;
  mem_req_t           mem_req;
  row_t               rd_row;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign clear_store = cfg_wr && (cfg_index == REG_DIRECTED || cfg_index == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      directed     <= 1'b0;
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_DIRECTED:     directed     <= cfg_data[0];
        REG_VERTEX_COUNT: vertex_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  gabm_store u_store (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear_store),
    .req    (mem_req),
    .rd_row (rd_row)
  );

  gabm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .directed     (directed),
    .vertex_count (vertex_count),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .mem_req      (mem_req),
    .rd_row       (rd_row)
  );

endmodule

[hw/rtl/gabm_checker.sv]
// port-level checker for the graph adjacency bit matrix, bound to the top level
`include "graph_adjacency_bit_matrix_assert.svh"

module gabm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input gabm_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input gabm_pkg::out_word_t out_word
);

  // stalled result word holds
  `GABM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // reset empties the output register
  `GABM_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid)

  // no new word is taken while a neighbor list is still open
  `GABM_ASSERT_NOW(a_list_blocks_input, out_valid && !out_word.last, in_stall)

  // neighbors of one list come out in ascending order
  `GABM_ASSERT_NEXT(a_list_ascending,
    out_valid && !out_stall && out_word.has_neighbor && !out_word.last,
    !out_valid || !out_word.has_neighbor || (out_word.neighbor > $past(out_word.neighbor)))

endmodule

bind graph_adjacency_bit_matrix gabm_checker u_checker (.*);

[dv/graph_adjacency_bit_matrix_test.sv]
// testbench for the graph adjacency bit matrix: edge operations checked word by word against a predictor
`timescale 1ns / 100ps

module graph_adjacency_bit_matrix_test;
  import gabm_pkg::*;

  localparam logic [1:0]             OP_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3  = 2'd3;
  localparam logic                   STATUS_OK    = 1'b0;
  localparam logic                   STATUS_RANGE = 1'b1;
  localparam int REPORT_LIMIT = 10;
  localparam int CFG_SETTLE   = 10;
  localparam int DRAIN_CYCLES = 80;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]     cfg_data  = '0;

  graph_adjacency_bit_matrix dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  row_t               adj_rows [MAX_VERTICES];
  logic               directed_mode;
  logic [COUNT_W-1:0] vertex_limit;
  out_word_t          pending_results [$];

  int mismatches    = 0;
  bit tx_gaps_on    = 1'b1;
  bit rx_stalls_on  = 1'b1;
  int hold_request  = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  function automatic int live_vertices();
    return (vertex_limit > MAX_COUNT) ? MAX_VERTICES : int'(vertex_limit);
  endfunction

  function automatic void reset_edges();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      adj_rows[i] = row_t'(1) << i;
    end
  endfunction

  function automatic void push_result(logic st, logic con, logic has, int nb, logic last);
    out_word_t r;
    r.status       = st;
    r.connected    = con;
    r.has_neighbor = has;
    r.neighbor     = VERTEX_W'(nb);
    r.last         = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_edge_results(input in_word_t w);
    int n;
    int src;
    int dst;
    int found;
    n     = live_vertices();
    src   = w.from_vertex;
    dst   = w.to_vertex;
    found = 0;
    if (w.operation == OP_UNUSED) return;
    if (w.operation == OP_NEIGHBORS) begin
      if (src >= n) begin
        push_result(STATUS_RANGE, 1'b0, 1'b0, 0, 1'b1);
        return;
      end
      for (int v = 0; v < n; v++) begin
        if (v != src && adj_rows[src][v]) begin
          push_result(STATUS_OK, 1'b0, 1'b1, v, 1'b0);
          found++;
        end
      end
      if (found == 0) push_result(STATUS_OK, 1'b0, 1'b0, 0, 1'b1);
      else pending_results[pending_results.size()-1].last = 1'b1;
      return;
    end
    if (src >= n || dst >= n) begin
      push_result(STATUS_RANGE, 1'b0, 1'b0, 0, 1'b1);
    end else if (w.operation == OP_CONNECT) begin
      adj_rows[src][dst] = 1'b1;
      if (!directed_mode) adj_rows[dst][src] = 1'b1;
      push_result(STATUS_OK, 1'b0, 1'b0, 0, 1'b1);
    end else begin
      push_result(STATUS_OK, adj_rows[src][dst], 1'b0, 0, 1'b1);
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %h", out_word));
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status, out_word.status));
        if (out_word.connected !== want.connected)
          flag_mismatch($sformatf("connected expected %0d got %0d",
                                  want.connected, out_word.connected));
        if (out_word.has_neighbor !== want.has_neighbor)
          flag_mismatch($sformatf("has_neighbor expected %0d got %0d",
                                  want.has_neighbor, out_word.has_neighbor));
        if (out_word.neighbor !== want.neighbor)
          flag_mismatch($sformatf("neighbor expected %0d got %0d",
                                  want.neighbor, out_word.neighbor));
        if (out_word.last !== want.last)
          flag_mismatch($sformatf("last expected %0d got %0d", want.last, out_word.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] op, input int src, input int dst);
    int gap;
    gap = 0;
    in_word <= in_word_t'{operation: op, from_vertex: VERTEX_W'(src), to_vertex: VERTEX_W'(dst)};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edge_results(in_word);
    if (tx_gaps_on && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_INDEX_W-1:0] idx, input int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COUNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_DIRECTED) begin
      directed_mode = value[0];
      reset_edges();
    end else if (idx == REG_VERTEX_COUNT) begin
      vertex_limit = COUNT_W'(value);
      reset_edges();
    end
  endtask

  task automatic test_reset_state();
    send_word(OP_NEIGHBORS, 0, 63);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, 0, 63);
    send_word(OP_UNUSED, 63, 63);
  endtask

  task automatic test_undirected_edges();
    send_word(OP_CONNECT, 0, 63);
    send_word(OP_QUERY, 63, 0);
    send_word(OP_CONNECT, 5, 5);
    send_word(OP_NEIGHBORS, 5, 0);
    send_word(OP_CONNECT, 0, 1);
    send_word(OP_NEIGHBORS, 0, 0);
    send_word(OP_NEIGHBORS, 63, 21);
  endtask

  task automatic test_range_limits();
    write_config(REG_VERTEX_COUNT, 10);
    send_word(OP_QUERY, 10, 0);
    send_word(OP_CONNECT, 0, 10);
    send_word(OP_NEIGHBORS, 10, 0);
    send_word(OP_CONNECT, 9, 0);
    send_word(OP_NEIGHBORS, 0, 42);
    write_config(REG_SPARE_2, 0);
    write_config(REG_SPARE_3, 127);
    send_word(OP_QUERY, 0, 9);
    send_word(OP_QUERY, 63, 63);
  endtask

  task automatic test_directed_edges();
    write_config(REG_DIRECTED, 7'h7f);
    send_word(OP_CONNECT, 3, 4);
    send_word(OP_QUERY, 4, 3);
    send_word(OP_QUERY, 3, 4);
    send_word(OP_NEIGHBORS, 4, 0);
    send_word(OP_NEIGHBORS, 3, 0);
  endtask

  task automatic test_config_corners();
    write_config(REG_VERTEX_COUNT, 0);
    send_word(OP_QUERY, 0, 0);
    write_config(REG_VERTEX_COUNT, 127);
    send_word(OP_QUERY, 63, 63);
    write_config(REG_DIRECTED, 7'h7e);
    write_config(REG_VERTEX_COUNT, 1);
    send_word(OP_NEIGHBORS, 0, 0);
    send_word(OP_CONNECT, 0, 1);
  endtask

  task automatic send_random_word();
    int n;
    int pick;
    n = live_vertices();
    pick = $urandom_range(0, 99);
    if (pick >= 92 || n == 0) begin
      send_word(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
    end else if (pick < 40) begin
      send_word(OP_CONNECT, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
    end else if (pick < 70) begin
      send_word(OP_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
    end else begin
      send_word(OP_NEIGHBORS, $urandom_range(0, n - 1), $urandom_range(0, 63));
    end
  endtask

  task automatic test_random_traffic();
    int dir_cfg [6];
    int cnt_cfg [6];
    dir_cfg = '{0, 1, 0, 1, 0, 1};
    cnt_cfg = '{64, 64, $urandom_range(6, 12), $urandom_range(3, 8), $urandom_range(65, 127), 2};
    for (int p = 0; p < 6; p++) begin
      write_config(REG_DIRECTED, dir_cfg[p]);
      write_config(REG_VERTEX_COUNT, cnt_cfg[p]);
      for (int i = 0; i < 15; i++) begin
        if (i % 10 == 0) begin
          tx_gaps_on   = ($urandom_range(0, 3) != 0);
          rx_stalls_on = ($urandom_range(0, 3) != 0);
        end
        send_random_word();
      end
    end
  endtask

  task automatic test_backpressure();
    write_config(REG_VERTEX_COUNT, 16);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_request = 60;
    for (int i = 0; i < 4; i++) send_word(OP_CONNECT, i, i + 8);
    for (int i = 0; i < 4; i++) send_word(OP_QUERY, i + 8, i);
    send_word(OP_NEIGHBORS, 0, 0);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    directed_mode = 1'b0;
    vertex_limit  = VERTEX_COUNT_RESET;
    reset_edges();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_undirected_edges();
    test_range_limits();
    test_directed_edges();
    test_config_corners();
    test_random_traffic();
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
